[rtl/multiset_intersection_core_macros.svh]
// Assertion macros shared by the checkers of the intersection core.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef MULTISET_INTERSECTION_CORE_MACROS_SVH
`define MULTISET_INTERSECTION_CORE_MACROS_SVH

`define MSI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define MSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/msi_pkg.sv]
package msi_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_PROBE = 2'd2
	} msi_func_e;

	localparam logic STATUS_MATCH = 1'b0;
	localparam logic STATUS_FULL  = 1'b1;

	typedef struct packed {
		logic [1:0]               func;
		logic signed [DATA_W-1:0] element;
	} msi_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] match_value;
		logic                     status;
	} msi_rsp_t;

	// Control that travels with each item along the chain
	typedef struct packed {
		logic       valid;
		logic [1:0] func;
		logic       done;
		logic       hit;
	} msi_ctl_t;

endpackage

[rtl/msi_cell.sv]
module msi_cell #(
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  msi_pkg::msi_ctl_t        prev_ctl,
	input  logic [ELEMENT_WIDTH-1:0] prev_key,
	output msi_pkg::msi_ctl_t        next_ctl,
	output logic [ELEMENT_WIDTH-1:0] next_key
);
	import msi_pkg::*;

	logic                     valid_q;
	logic [COUNT_W-1:0]       count_q;
	logic [ELEMENT_WIDTH-1:0] key_q;
	msi_ctl_t                 next_ctl_q;
	logic [ELEMENT_WIDTH-1:0] next_key_q;

	logic                     match;
	logic                     valid_d;
	logic [COUNT_W-1:0]       count_d;
	logic                     key_load;
	msi_ctl_t                 ctl_d;

	assign match = valid_q && (key_q == prev_key);

	always_comb begin
		ctl_d    = prev_ctl;
		valid_d  = valid_q;
		count_d  = count_q;
		key_load = 1'b0;
		if (prev_ctl.valid && !prev_ctl.done) begin
			case (prev_ctl.func)
				FUNC_CLEAR: begin
					valid_d = 1'b0;
					count_d = '0;
				end
				FUNC_LOAD: begin
					if (match) begin
						if (count_q != COUNT_MAX)
							count_d = count_q + 1'b1;
						ctl_d.done = 1'b1;
					end else if (!valid_q) begin
						// valid entries form a prefix: first free cell takes the key
						valid_d    = 1'b1;
						count_d    = COUNT_W'(1);
						key_load   = 1'b1;
						ctl_d.done = 1'b1;
					end
				end
				FUNC_PROBE: begin
					if (match) begin
						ctl_d.done = 1'b1;
						if (count_q != '0) begin
							count_d   = count_q - 1'b1;
							ctl_d.hit = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			count_q    <= '0;
			next_ctl_q <= '0;
		end else if (adv) begin
			valid_q    <= valid_d;
			count_q    <= count_d;
			next_ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			next_key_q <= prev_key;
			if (key_load)
				key_q <= prev_key;
		end
	end

	assign next_ctl = next_ctl_q;
	assign next_key = next_key_q;

endmodule

[rtl/multiset_intersection_core.sv]
// Each item walks the row of entry cells, one cell a cycle, then the output register.
// Throughput: one item per cycle unless a stalled result holds the row.
// Clear, load and probe items all travel the full row, so results leave in item order.
// The whole row holds while a result waits on a stalled output.
// Reset empties every entry at once; no clearing pass is needed.
module multiset_intersection_core #(
	parameter int TABLE_DEPTH   = 64,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  msi_pkg::msi_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output msi_pkg::msi_rsp_t rsp
);
	import msi_pkg::*;

	localparam int MW = (ELEMENT_WIDTH > DATA_W) ? ELEMENT_WIDTH : DATA_W;

	msi_ctl_t                 ctl_chain [TABLE_DEPTH+1];
	logic [ELEMENT_WIDTH-1:0] key_chain [TABLE_DEPTH+1];

	logic          adv;
	logic [MW-1:0] elem_wide;
	logic [MW-1:0] key_wide;
	msi_ctl_t      ctl_in;
	msi_ctl_t      last;
	logic          res_valid;
	logic          rsp_valid_q;
	msi_rsp_t      rsp_q;

	// hold the row while a result is stuck at the output
	assign adv       = !(rsp_valid_q && rsp_stall);
	assign req_stall = !adv;

	assign elem_wide = MW'(req.element);

	always_comb begin
		ctl_in       = '0;
		ctl_in.valid = req_valid && adv;
		ctl_in.func  = req.func;
	end
	assign ctl_chain[0] = ctl_in;
	assign key_chain[0] = elem_wide[ELEMENT_WIDTH-1:0];

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		msi_cell #(
			.ELEMENT_WIDTH(ELEMENT_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.prev_ctl (ctl_chain[i]),
			.prev_key (key_chain[i]),
			.next_ctl (ctl_chain[i+1]),
			.next_key (key_chain[i+1])
		);
	end

	assign last     = ctl_chain[TABLE_DEPTH];
	assign key_wide = MW'(key_chain[TABLE_DEPTH]);
	// an unplaced load means the table was full
	assign res_valid = last.valid &&
		((last.func == FUNC_LOAD && !last.done) || (last.func == FUNC_PROBE && last.hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (adv)
			rsp_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			if (last.func == FUNC_LOAD) begin
				rsp_q.match_value <= '0;
				rsp_q.status      <= STATUS_FULL;
			end else begin
				rsp_q.match_value <= key_wide[DATA_W-1:0];
				rsp_q.status      <= STATUS_MATCH;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/msi_checker.sv]
`include "multiset_intersection_core_macros.svh"

module msi_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input msi_pkg::msi_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input msi_pkg::msi_rsp_t rsp
);
	import msi_pkg::*;

	// a full-table answer never carries a value
	`MSI_ASSERT_SAME(a_full_zero, rsp_valid && rsp.status == STATUS_FULL, rsp.match_value == '0, "full status with nonzero value")

	// input side stalls exactly when a result is stuck
	`MSI_ASSERT_SAME(a_stall_link, 1'b1, req_stall == (rsp_valid && rsp_stall), "input stall not tied to output backpressure")

	`MSI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

	`MSI_ASSERT_SAME(a_rsp_drop, $fell(rsp_valid), $past(!rsp_stall), "result withdrawn while stalled")

endmodule

bind multiset_intersection_core msi_checker u_msi_checker (.*);
